// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the checker module of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion clocked on the rising edge, off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked in the next cycle, same clocking as above.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lcgdps_pkg.sv -----
// ----------------------------------------------------------------------------
// lcgdps_pkg
// Constants and types of the generator draw-pattern search unit.
// ----------------------------------------------------------------------------
package lcgdps_pkg;

    localparam int unsigned STATE_W = 32;
    localparam int unsigned HALF_W  = 16;
    localparam int unsigned DRAW_W  = 15;
    localparam int unsigned IV_W    = 5;
    localparam int unsigned CODE_W  = 2;

    localparam logic [STATE_W-1:0] LCG_MUL = 32'h41C6_4E6D;
    localparam logic [STATE_W-1:0] LCG_ADD = 32'h0000_6073;

    localparam logic [CODE_W-1:0] CODE_NONE      = 2'd0;
    localparam logic [CODE_W-1:0] CODE_CONSEC    = 2'd1;
    localparam logic [CODE_W-1:0] CODE_SKIP_PRE  = 2'd2;
    localparam logic [CODE_W-1:0] CODE_SKIP_MID  = 2'd3;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SEED = 6'b000010,
        ST_D3   = 6'b000100,
        ST_D4   = 6'b001000,
        ST_D5   = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    // sequencer -> datapath
    typedef struct packed {
        logic accept;     // input beat taken, capture payload
        logic sel_seed;   // unit operand is {first, k}, else the stored state
        logic s_load;     // store unit result
        logic d3_load;
        logic d4_load;
        logic k_clr;
        logic k_inc;
        logic code_load;  // latch result code
        logic code_zero;  // latched code is "no match"
        logic out_load;   // move code into the output register
    } ctrl_t;

    // datapath -> sequencer
    typedef struct packed {
        logic                in_valid;
        logic                out_busy;   // output register full and not taken
        logic                hi_match;   // successor top half equals pid high half
        logic                k_last;
        logic [CODE_W-1:0]   pat_code;   // pattern test on the fifth state
    } stat_t;

endpackage

// ----- rtl/lcgdps_lcg_unit.sv -----
// ----------------------------------------------------------------------------
// lcgdps_lcg_unit
// Shared generator step: next = state * multiplier + increment, mod 2^32.
// ----------------------------------------------------------------------------
module lcgdps_lcg_unit (
    input  logic [lcgdps_pkg::STATE_W-1:0] state_i,
    output logic [lcgdps_pkg::STATE_W-1:0] next_o
);
    import lcgdps_pkg::*;

    logic [STATE_W-1:0] prod;

    assign prod   = state_i * LCG_MUL;
    assign next_o = prod + LCG_ADD;

endmodule

// ----- rtl/lcgdps_seq.sv -----
// ----------------------------------------------------------------------------
// lcgdps_seq
// Sequencer: walks the candidates and the three follow-up draws per hit.
// ----------------------------------------------------------------------------
module lcgdps_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  lcgdps_pkg::stat_t   stat_i,
    output lcgdps_pkg::ctrl_t   ctrl_o,
    output logic                in_ready_o
);
    import lcgdps_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctrl_o     = '0;
        in_ready_o = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready_o = 1'b1;
                if (stat_i.in_valid) begin
                    ctrl_o.accept = 1'b1;
                    ctrl_o.k_clr  = 1'b1;
                    state_next    = ST_SEED;
                end
            end
            ST_SEED: begin
                ctrl_o.sel_seed = 1'b1;
                if (stat_i.hi_match) begin
                    ctrl_o.s_load = 1'b1;
                    state_next    = ST_D3;
                end else if (stat_i.k_last) begin
                    ctrl_o.code_load = 1'b1;
                    ctrl_o.code_zero = 1'b1;
                    state_next       = ST_DONE;
                end else begin
                    ctrl_o.k_inc = 1'b1;
                end
            end
            ST_D3: begin
                ctrl_o.s_load  = 1'b1;
                ctrl_o.d3_load = 1'b1;
                state_next     = ST_D4;
            end
            ST_D4: begin
                ctrl_o.s_load  = 1'b1;
                ctrl_o.d4_load = 1'b1;
                state_next     = ST_D5;
            end
            ST_D5: begin
                // a miss on the last candidate latches CODE_NONE from the test
                if (stat_i.pat_code != CODE_NONE || stat_i.k_last) begin
                    ctrl_o.code_load = 1'b1;
                    state_next       = ST_DONE;
                end else begin
                    ctrl_o.k_inc = 1'b1;
                    state_next   = ST_SEED;
                end
            end
            ST_DONE: begin
                if (!stat_i.out_busy) begin
                    ctrl_o.out_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/lcg_draw_pattern_search_unit.sv -----
// ----------------------------------------------------------------------------
// lcg_draw_pattern_search_unit
// Searches the 65536 generator states seeded by the low half of pid for a
// draw pattern that yields the two packed 15-bit value words.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  s_       | in  | s_valid / s_ready  | s_pid, s_iv_hp .. s_iv_spd
//  m_       | out | m_valid / m_ready  | m_method_code
//
//  One generator step per cycle through a single shared multiply-add unit.
//  Each candidate seed is stepped in ST_SEED; a candidate whose successor
//  matches pid high half also takes the draws of ST_D3, ST_D4 and ST_D5.
//  Early exit on the first pattern match.
//  s_ready is high only while idle; a pending result in the output
//  register does not block the next beat, only the next result.
//  Reset: synchronous, active low, clears sequencer and m_valid.
// ----------------------------------------------------------------------------
module lcg_draw_pattern_search_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [31:0]                       s_pid,
    input  logic [lcgdps_pkg::IV_W-1:0]       s_iv_hp,
    input  logic [lcgdps_pkg::IV_W-1:0]       s_iv_atk,
    input  logic [lcgdps_pkg::IV_W-1:0]       s_iv_def,
    input  logic [lcgdps_pkg::IV_W-1:0]       s_iv_spe,
    input  logic [lcgdps_pkg::IV_W-1:0]       s_iv_spa,
    input  logic [lcgdps_pkg::IV_W-1:0]       s_iv_spd,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lcgdps_pkg::CODE_W-1:0]     m_method_code
);
    import lcgdps_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    logic [HALF_W-1:0]  first_reg, second_reg;
    logic [DRAW_W-1:0]  w1_reg, w2_reg;
    logic [HALF_W-1:0]  k_reg;
    logic [STATE_W-1:0] s_reg;
    logic [DRAW_W-1:0]  d3_reg, d4_reg;
    logic [CODE_W-1:0]  code_reg;
    logic [CODE_W-1:0]  out_code_reg;
    logic               m_valid_reg, m_valid_next;

    logic [STATE_W-1:0] unit_in, unit_out;
    logic [DRAW_W-1:0]  d5;
    logic [CODE_W-1:0]  pat_code;

    assign unit_in = ctrl.sel_seed ? {first_reg, k_reg} : s_reg;

    lcgdps_lcg_unit u_lcg (
        .state_i (unit_in),
        .next_o  (unit_out)
    );

    assign d5 = unit_out[STATE_W-2 -: DRAW_W];

    // lowest code wins when several patterns fit
    always_comb begin
        priority if (d3_reg == w1_reg && d4_reg == w2_reg) begin
            pat_code = CODE_CONSEC;
        end else if (d4_reg == w1_reg && d5 == w2_reg) begin
            pat_code = CODE_SKIP_PRE;
        end else if (d3_reg == w1_reg && d5 == w2_reg) begin
            pat_code = CODE_SKIP_MID;
        end else begin
            pat_code = CODE_NONE;
        end
    end

    assign stat.in_valid = s_valid;
    assign stat.out_busy = m_valid_reg & ~m_ready;
    assign stat.hi_match = (unit_out[STATE_W-1 -: HALF_W] == second_reg);
    assign stat.k_last   = (k_reg == {HALF_W{1'b1}});
    assign stat.pat_code = pat_code;

    lcgdps_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .stat_i     (stat),
        .ctrl_o     (ctrl),
        .in_ready_o (s_ready)
    );

    // payload registers
    always_ff @(posedge aclk) begin
        if (ctrl.accept) begin
            first_reg  <= s_pid[HALF_W-1:0];
            second_reg <= s_pid[2*HALF_W-1:HALF_W];
            w1_reg     <= {s_iv_def, s_iv_atk, s_iv_hp};
            w2_reg     <= {s_iv_spd, s_iv_spa, s_iv_spe};
        end
        if (ctrl.k_clr) begin
            k_reg <= '0;
        end else if (ctrl.k_inc) begin
            k_reg <= k_reg + 1'b1;
        end
        if (ctrl.s_load) begin
            s_reg <= unit_out;
        end
        if (ctrl.d3_load) begin
            d3_reg <= unit_out[STATE_W-2 -: DRAW_W];
        end
        if (ctrl.d4_load) begin
            d4_reg <= unit_out[STATE_W-2 -: DRAW_W];
        end
        if (ctrl.code_load) begin
            code_reg <= ctrl.code_zero ? CODE_NONE : pat_code;
        end
        if (ctrl.out_load) begin
            out_code_reg <= code_reg;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctrl.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_method_code = out_code_reg;

endmodule

// ----- rtl/lcgdps_checker.sv -----
// ----------------------------------------------------------------------------
// lcgdps_checker
// Port-level checks of the draw-pattern search unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcgdps_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [lcgdps_pkg::CODE_W-1:0]     m_method_code
);
    import lcgdps_pkg::*;

    logic m_stall;

    assign m_stall = m_valid && !m_ready;

    // a stalled result beat stays up
    `ASSERT_NEXT(a_m_hold, aclk, aresetn, m_stall, m_valid, "m_valid dropped")
    // and keeps its code
    `ASSERT_NEXT(a_m_stable, aclk, aresetn, m_stall, $stable(m_method_code), "code moved")
    // the search occupies the unit right after a beat is taken
    `ASSERT_NEXT(a_busy, aclk, aresetn, s_valid && s_ready, !s_ready, "s_ready high during search")
    // a new result appears only as the search hands back to idle
    `ASSERT_CLK(a_done_idle, aclk, aresetn, $rose(m_valid) |-> s_ready, "result without return to idle")

endmodule

bind lcg_draw_pattern_search_unit lcgdps_checker u_lcgdps_checker (.*);

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lcg_draw_pattern_search_unit. Queries are mostly
// built from known generator seeds so the search exits early with a known
// pattern; noise and single-bit-corrupted queries force full scans. Every
// accepted query is predicted by a local model of the search, and each result
// beat is compared in order against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

    import lcgdps_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 40_000_000;
    localparam int unsigned HOLD_CYCLES = 150_000;
    localparam int unsigned DRAIN_CYCLES = 70_000;
    localparam int unsigned RAND_ITEMS = 100;
    localparam int unsigned CAND_COUNT = 65536;

    typedef struct {
        logic [31:0]     pid;
        logic [IV_W-1:0] iv_hp;
        logic [IV_W-1:0] iv_atk;
        logic [IV_W-1:0] iv_def;
        logic [IV_W-1:0] iv_spe;
        logic [IV_W-1:0] iv_spa;
        logic [IV_W-1:0] iv_spd;
    } search_query_t;

    class method_code_board;
        logic [CODE_W-1:0] expected_codes[$];
        int fails;

        static function logic [STATE_W-1:0] next_state(logic [STATE_W-1:0] s);
            return s * LCG_MUL + LCG_ADD;
        endfunction

        function logic [CODE_W-1:0] predict_code(search_query_t q);
            logic [STATE_W-1:0] s1, s2, s3, s4, s5;
            logic [DRAW_W-1:0] w1, w2, d3, d4, d5;
            logic [CODE_W-1:0] code;
            w1 = {q.iv_def, q.iv_atk, q.iv_hp};
            w2 = {q.iv_spd, q.iv_spa, q.iv_spe};
            code = CODE_NONE;
            for (int k = 0; k < CAND_COUNT && code == CODE_NONE; k++) begin
                s1 = {q.pid[15:0], 16'(k)};
                s2 = next_state(s1);
                if (s2[31:16] != q.pid[31:16]) continue;
                s3 = next_state(s2);
                s4 = next_state(s3);
                s5 = next_state(s4);
                d3 = s3[30:16];
                d4 = s4[30:16];
                d5 = s5[30:16];
                if (d3 == w1 && d4 == w2) code = CODE_CONSEC;
                else if (d4 == w1 && d5 == w2) code = CODE_SKIP_PRE;
                else if (d3 == w1 && d5 == w2) code = CODE_SKIP_MID;
            end
            return code;
        endfunction

        function void note_query(search_query_t q);
            expected_codes.push_back(predict_code(q));
        endfunction

        function void check_code(logic [CODE_W-1:0] got);
            logic [CODE_W-1:0] want;
            if (expected_codes.size() == 0) begin
                $error("method_code: result beat with no query pending, actual %0d", got);
                fails++;
            end else begin
                want = expected_codes.pop_front();
                if (got !== want) begin
                    $error("method_code mismatch: expected %0d, actual %0d", want, got);
                    fails++;
                end
            end
        endfunction

        function int pending();
            return expected_codes.size();
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [31:0]         s_pid;
    logic [IV_W-1:0]     s_iv_hp, s_iv_atk, s_iv_def, s_iv_spe, s_iv_spa, s_iv_spd;
    logic                m_valid;
    logic                m_ready;
    logic [CODE_W-1:0]   m_method_code;

    method_code_board board;
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    bit hold_rx;
    int unsigned cycles;

    lcg_draw_pattern_search_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pid         (s_pid),
        .s_iv_hp       (s_iv_hp),
        .s_iv_atk      (s_iv_atk),
        .s_iv_def      (s_iv_def),
        .s_iv_spe      (s_iv_spe),
        .s_iv_spa      (s_iv_spa),
        .s_iv_spd      (s_iv_spd),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_method_code (m_method_code)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Query with pid from seed and its successor, words from the later draws.
    function automatic search_query_t seeded_query(logic [STATE_W-1:0] seed,
                                                   logic [CODE_W-1:0] pat);
        search_query_t q;
        logic [STATE_W-1:0] s2, s3, s4, s5;
        logic [DRAW_W-1:0] w1, w2;
        s2 = method_code_board::next_state(seed);
        s3 = method_code_board::next_state(s2);
        s4 = method_code_board::next_state(s3);
        s5 = method_code_board::next_state(s4);
        case (pat)
            CODE_SKIP_PRE: begin
                w1 = s4[30:16];
                w2 = s5[30:16];
            end
            CODE_SKIP_MID: begin
                w1 = s3[30:16];
                w2 = s5[30:16];
            end
            default: begin
                w1 = s3[30:16];
                w2 = s4[30:16];
            end
        endcase
        q.pid = {s2[31:16], seed[31:16]};
        {q.iv_def, q.iv_atk, q.iv_hp} = w1;
        {q.iv_spd, q.iv_spa, q.iv_spe} = w2;
        return q;
    endfunction

    function automatic search_query_t noise_query();
        search_query_t q;
        q.pid = $urandom;
        {q.iv_spd, q.iv_spa, q.iv_spe, q.iv_def, q.iv_atk, q.iv_hp} = 30'($urandom);
        return q;
    endfunction

    // Corrupt one bit out of pid and the six value fields.
    function automatic search_query_t flip_bit(search_query_t q, int unsigned idx);
        logic [29:0] ivs;
        ivs = {q.iv_spd, q.iv_spa, q.iv_spe, q.iv_def, q.iv_atk, q.iv_hp};
        if (idx < 32) q.pid[idx] = ~q.pid[idx];
        else ivs[idx - 32] = ~ivs[idx - 32];
        {q.iv_spd, q.iv_spa, q.iv_spe, q.iv_def, q.iv_atk, q.iv_hp} = ivs;
        return q;
    endfunction

    // Seed whose fourth and fifth draws agree, so two patterns hit at once.
    function automatic logic [STATE_W-1:0] twin_draw_seed();
        logic [STATE_W-1:0] seed, s4, s5;
        seed = $urandom;
        for (int i = 0; i < (1 << 21); i++) begin
            seed = {seed[31:16], 16'($urandom_range(0, 4095))};
            s4 = method_code_board::next_state(method_code_board::next_state(
                 method_code_board::next_state(seed)));
            s5 = method_code_board::next_state(s4);
            if (s4[30:16] == s5[30:16]) break;
            seed[31:16] = $urandom;
        end
        return seed;
    endfunction

    // Two candidates of one pid low half whose successors share the top half.
    task automatic shared_hit_seeds(output logic [STATE_W-1:0] early,
                                    output logic [STATE_W-1:0] late);
        int seen [0:65535];
        logic [15:0] first;
        logic [STATE_W-1:0] s2;
        bit found;
        found = 1'b0;
        early = $urandom;
        late = early;
        for (int t = 0; t < 16 && !found; t++) begin
            first = $urandom;
            foreach (seen[i]) seen[i] = -1;
            for (int k = 0; k < CAND_COUNT && !found; k++) begin
                s2 = method_code_board::next_state({first, 16'(k)});
                if (seen[s2[31:16]] >= 0) begin
                    early = {first, 16'(seen[s2[31:16]])};
                    late = {first, 16'(k)};
                    found = 1'b1;
                end else begin
                    seen[s2[31:16]] = k;
                end
            end
        end
    endtask

    task automatic send_query(search_query_t q);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_pid     <= q.pid;
        s_iv_hp   <= q.iv_hp;
        s_iv_atk  <= q.iv_atk;
        s_iv_def  <= q.iv_def;
        s_iv_spe  <= q.iv_spe;
        s_iv_spa  <= q.iv_spa;
        s_iv_spd  <= q.iv_spd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_query(q);
    endtask

    // Result side: random back-pressure, plus one long hold on request.
    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) board.check_code(m_method_code);
            if (hold_rx) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_rx = 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("FAIL lcg_draw_pattern_search_unit");
        $finish;
    end

    initial begin
        logic [STATE_W-1:0] seed, early, late;
        search_query_t q;
        int unsigned pick;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_pid = '0;
        s_iv_hp = '0;
        s_iv_atk = '0;
        s_iv_def = '0;
        s_iv_spe = '0;
        s_iv_spa = '0;
        s_iv_spd = '0;
        tx_idle_pct = 17;
        rx_idle_pct = 48;
        hold_rx = 1'b0;
        board = new();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes, each pattern, candidate extremes
        q.pid = '0;
        {q.iv_spd, q.iv_spa, q.iv_spe, q.iv_def, q.iv_atk, q.iv_hp} = '0;
        send_query(q);
        q.pid = '1;
        {q.iv_spd, q.iv_spa, q.iv_spe, q.iv_def, q.iv_atk, q.iv_hp} = '1;
        send_query(q);
        send_query(seeded_query({16'($urandom), 16'h0000}, CODE_CONSEC));
        send_query(seeded_query({16'($urandom), 16'h0000}, CODE_SKIP_PRE));
        send_query(seeded_query({16'($urandom), 16'h0000}, CODE_SKIP_MID));
        send_query(seeded_query({16'($urandom), 16'hFFFF}, CODE_CONSEC));
        send_query(seeded_query({16'($urandom), 16'hFFFF}, CODE_SKIP_PRE));
        send_query(seeded_query({16'($urandom), 16'hFFFF}, CODE_SKIP_MID));
        send_query(seeded_query({16'h0000, 16'($urandom_range(0, 255))}, CODE_SKIP_PRE));
        send_query(seeded_query({16'hFFFF, 16'($urandom_range(0, 255))}, CODE_SKIP_MID));
        // two patterns on one candidate: lowest code must win
        send_query(seeded_query(twin_draw_seed(), CODE_SKIP_MID));
        // two hits on the same pid: the later one matches, the earlier is skipped
        shared_hit_seeds(early, late);
        send_query(seeded_query(late, CODE_CONSEC));
        send_query(seeded_query(early, CODE_SKIP_PRE));
        send_query(flip_bit(seeded_query({16'($urandom), 16'h0010}, CODE_CONSEC), 61));

        // let everything drain before the random part
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);

        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i == 0) hold_rx = 1'b1;
            if (i == RAND_ITEMS / 3) begin
                tx_idle_pct = 48;
                rx_idle_pct = 17;
            end
            if (i == 2 * RAND_ITEMS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            pick = $urandom_range(0, 99);
            seed[31:16] = $urandom;
            seed[15:0] = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 2047));
            q = seeded_query(seed, CODE_W'($urandom_range(1, 3)));
            if (pick < 15) q = noise_query();
            else if (pick < 25) q = flip_bit(q, $urandom_range(0, 61));
            send_query(q);
        end
        s_valid <= 1'b0;

        while (board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.fails == 0) begin
            $display("PASS lcg_draw_pattern_search_unit");
        end else begin
            $display("FAIL lcg_draw_pattern_search_unit");
        end
        $finish;
    end

endmodule
